// ===== src/best_fit_interval_allocator_defines.svh =====
// Assertion macros used by the allocator checker.
`ifndef BEST_FIT_INTERVAL_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_INTERVAL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFIA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfia: same-cycle check failed");

// next-cycle implication
`define BFIA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfia: next-cycle check failed");

`endif

// ===== src/bfia_pkg.sv =====
// Types and codes for the best-fit interval allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfia_pkg;

   localparam int SIZE_W = 21;
   localparam int OUT_ADDR_W = 20;
   localparam logic [SIZE_W-1:0] SIZE_MASK = '1;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_MERGE = 2'd2;

   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_FAIL = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [SIZE_W-1:0]     req_size;
      logic [OUT_ADDR_W-1:0] free_start;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [OUT_ADDR_W-1:0] alloc_addr;
      logic [SIZE_W-1:0]     largest_free;
      logic [SIZE_W-1:0]     used_bytes;
   } rsp_type;

   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_FIT   = 9'b000000100,
      ST_MOVE  = 9'b000001000,
      ST_SEL   = 9'b000010000,
      ST_SWAP  = 9'b000100000,
      ST_FLUSH = 9'b001000000,
      ST_CLOSE = 9'b010000000,
      ST_MAXS  = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

// ===== src/best_fit_interval_allocator.sv =====
// Best-fit free interval allocator with coalescing, table held in one RAM.
//
//  channel  ports                          handshake
//  command  start, busy, req_payload       taken when start && !busy
//  result   rsp_strobe, rsp_payload        one-cycle strobe, no backpressure
//  csr      csr_wr_en, csr_wr_data         heap_size, written on any enable
//
// A command is accepted in idle, then a closing max-size scan reads every stored
// interval; strobe and idle follow it. Allocate inserts a best-fit scan before it
// and, for an exact fit that is not the last entry, a move state that fills the
// slot from the last entry. Coalesce runs a selection sort over the RAM.
// The result receiver cannot stall.
// Reset loads the initial interval in the init state; busy is high meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_interval_allocator
   import bfia_pkg::*;
#(
   parameter int MAX_INTERVALS = 64,
   parameter int ADDR_BITS = 20
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload,
   input  wire logic    csr_wr_en,
   input  wire logic [SIZE_W-1:0] csr_wr_data
);

   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int SW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;
   localparam int MW = SW + SIZE_W;
   localparam logic [SW-1:0] AMASK = (SW'(1) << ADDR_BITS) - SW'(1);
   localparam int FB = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
   localparam logic [SW-1:0] FMASK = (SW'(1) << FB) - SW'(1);
   localparam logic [SIZE_W:0] HLIM = (ADDR_BITS < SIZE_W) ?
      ((SIZE_W+1)'(1) << ADDR_BITS) : ((SIZE_W+1)'(1) << SIZE_W);
   localparam logic [CW-1:0] CMAX = CW'(MAX_INTERVALS);

   function automatic logic [SIZE_W-1:0] clamp_heap(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = ({1'b0, v} > HLIM) ? HLIM[SIZE_W-1:0] : v;
      return r;
   endfunction

   localparam logic [SIZE_W-1:0] RST_HEAP = clamp_heap(SIZE_W'(65536));

   logic [MW-1:0] mem_ff [MAX_INTERVALS];
   logic [MW-1:0] rdata_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [MW-1:0] wr_data;

   state_type state_ff, state_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [SIZE_W-1:0] live_ff, live_in;
   logic [SIZE_W-1:0] req_ff, req_in;
   logic          found_ff, found_in;
   logic [SW-1:0] bst_ff, bst_in;
   logic [SIZE_W-1:0] bsz_ff, bsz_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic          mvalid_ff, mvalid_in;
   logic [SW-1:0] mst_ff, mst_in;
   logic [SIZE_W-1:0] msz_ff, msz_in;
   logic [IW-1:0] midx_ff, midx_in;
   logic [MW-1:0] pval_ff, pval_in;
   logic          accv_ff, accv_in;
   logic [SW-1:0] ast_ff, ast_in;
   logic [SIZE_W-1:0] asz_ff, asz_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] k_ff, k_in;
   logic [SIZE_W-1:0] max_ff, max_in;
   logic [1:0]    status_ff, status_in;
   logic [OUT_ADDR_W-1:0] addr_ff, addr_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [SW-1:0]     rd_st;
   logic [SIZE_W-1:0] rd_sz;
   logic              scanning;
   logic              scan_done;
   logic              adv;
   logic [CW-1:0]     p_nx;
   logic [SIZE_W:0]   live_sum;
   logic [SIZE_W-1:0] heap_cl;
   logic              can_merge;

   assign rd_st = rdata_ff[MW-1:SIZE_W];
   assign rd_sz = rdata_ff[SIZE_W-1:0];
   assign scanning = (state_ff == ST_FIT) || (state_ff == ST_SEL) || (state_ff == ST_MAXS);
   assign scan_done = scanning && (ptr_ff >= count_ff) && !rd_vld_ff;
   assign live_sum = {1'b0, live_ff} + {1'b0, req_ff};
   assign heap_cl = clamp_heap(csr_wr_data);
   assign p_nx = p_ff + CW'(1);
   assign can_merge = (({1'b0, ast_ff} + (SW+1)'(asz_ff)) == {1'b0, mst_ff}) &&
                      (({1'b0, asz_ff} + {1'b0, msz_ff}) <= {1'b0, SIZE_MASK});

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff;
      rd_vld_in = 1'b0;
      count_in = count_ff;
      live_in = live_ff;
      req_in = req_ff;
      found_in = found_ff;
      bst_in = bst_ff;
      bsz_in = bsz_ff;
      bidx_in = bidx_ff;
      mvalid_in = mvalid_ff;
      mst_in = mst_ff;
      msz_in = msz_ff;
      midx_in = midx_ff;
      pval_in = pval_ff;
      accv_in = accv_ff;
      ast_in = ast_ff;
      asz_in = asz_ff;
      p_in = p_ff;
      k_in = k_ff;
      max_in = max_ff;
      status_in = status_ff;
      addr_in = addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      rd_addr = ptr_ff[IW-1:0];
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      adv = 1'b0;

      if (scanning && (ptr_ff < count_ff)) begin
         ptr_in = ptr_ff + CW'(1);
         rd_vld_in = 1'b1;
      end

      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            wr_data = {SW'(0), RST_HEAP};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_payload.req_size;
               status_in = STS_OK;
               addr_in = '0;
               ptr_in = '0;
               max_in = '0;
               case (req_payload.cmd)
                  CMD_ALLOC: begin
                     found_in = 1'b0;
                     state_in = ST_FIT;
                  end
                  CMD_FREE: begin
                     if (req_payload.req_size != '0) begin
                        if (count_ff >= CMAX) begin
                           status_in = STS_FULL;
                        end else begin
                           wr_en = 1'b1;
                           wr_addr = count_ff[IW-1:0];
                           wr_data = {SW'(req_payload.free_start) & FMASK,
                                      req_payload.req_size};
                           count_in = count_ff + CW'(1);
                           live_in = (live_ff > req_payload.req_size) ?
                                     live_ff - req_payload.req_size : '0;
                        end
                     end
                     state_in = ST_MAXS;
                  end
                  CMD_MERGE: begin
                     if (count_ff == '0) begin
                        state_in = ST_MAXS;
                     end else begin
                        p_in = '0;
                        k_in = '0;
                        accv_in = 1'b0;
                        mvalid_in = 1'b0;
                        state_in = ST_SEL;
                     end
                  end
                  default: begin
                     state_in = ST_MAXS;
                  end
               endcase
            end
         end
         ST_FIT: begin
            if (rd_vld_ff && (rd_sz >= req_ff) &&
                (!found_ff || (rd_sz < bsz_ff) || ((rd_sz == bsz_ff) && (rd_st < bst_ff)))) begin
               found_in = 1'b1;
               bst_in = rd_st;
               bsz_in = rd_sz;
               bidx_in = rd_idx_ff;
            end
            if (scan_done) begin
               ptr_in = '0;
               state_in = ST_MAXS;
               if (!found_ff) begin
                  status_in = STS_FAIL;
               end else begin
                  addr_in = OUT_ADDR_W'(bst_ff & AMASK);
                  live_in = live_sum[SIZE_W] ? SIZE_MASK : live_sum[SIZE_W-1:0];
                  if (bsz_ff == req_ff) begin
                     count_in = count_ff - CW'(1);
                     if (CW'(bidx_ff) != (count_ff - CW'(1))) begin
                        rd_addr = IW'(count_ff - CW'(1));
                        state_in = ST_MOVE;
                     end
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = bidx_ff;
                     wr_data = {bst_ff + SW'(req_ff), bsz_ff - req_ff};
                  end
               end
            end
         end
         ST_MOVE: begin
            wr_en = 1'b1;
            wr_addr = bidx_ff;
            wr_data = rdata_ff;
            ptr_in = '0;
            state_in = ST_MAXS;
         end
         ST_SEL: begin
            if (rd_vld_ff) begin
               if (rd_idx_ff == p_ff[IW-1:0]) begin
                  pval_in = rdata_ff;
               end
               if (!mvalid_ff || (rd_st < mst_ff) || ((rd_st == mst_ff) && (rd_sz < msz_ff))) begin
                  mvalid_in = 1'b1;
                  mst_in = rd_st;
                  msz_in = rd_sz;
                  midx_in = rd_idx_ff;
               end
            end
            if (scan_done) begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            if (midx_ff != p_ff[IW-1:0]) begin
               wr_en = 1'b1;
               wr_addr = midx_ff;
               wr_data = pval_ff;
            end
            if (!accv_ff) begin
               accv_in = 1'b1;
               ast_in = mst_ff;
               asz_in = msz_ff;
               adv = 1'b1;
            end else if (can_merge) begin
               asz_in = asz_ff + msz_ff;
               adv = 1'b1;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            wr_en = 1'b1;
            wr_addr = k_ff[IW-1:0];
            wr_data = {ast_ff, asz_ff};
            k_in = k_ff + CW'(1);
            ast_in = mst_ff;
            asz_in = msz_ff;
            adv = 1'b1;
         end
         ST_CLOSE: begin
            wr_en = 1'b1;
            wr_addr = k_ff[IW-1:0];
            wr_data = {ast_ff, asz_ff};
            count_in = k_ff + CW'(1);
            ptr_in = '0;
            state_in = ST_MAXS;
         end
         ST_MAXS: begin
            if (rd_vld_ff && (rd_sz > max_ff)) begin
               max_in = rd_sz;
            end
            if (scan_done) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.alloc_addr = addr_ff;
               rsp_in.largest_free = max_ff;
               rsp_in.used_bytes = live_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (adv) begin
         if (p_nx >= count_ff) begin
            state_in = ST_CLOSE;
         end else begin
            p_in = p_nx;
            ptr_in = p_nx;
            mvalid_in = 1'b0;
            state_in = ST_SEL;
         end
      end

      if (csr_wr_en) begin
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data = {SW'(0), heap_cl};
         count_in = (heap_cl != '0) ? CW'(1) : '0;
         live_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         rd_vld_ff <= 1'b0;
         count_ff <= CW'(1);
         live_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_vld_ff <= rd_vld_in;
         count_ff <= count_in;
         live_ff <= live_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rd_idx_ff <= ptr_ff[IW-1:0];
      req_ff <= req_in;
      found_ff <= found_in;
      bst_ff <= bst_in;
      bsz_ff <= bsz_in;
      bidx_ff <= bidx_in;
      mvalid_ff <= mvalid_in;
      mst_ff <= mst_in;
      msz_ff <= msz_in;
      midx_ff <= midx_in;
      pval_ff <= pval_in;
      accv_ff <= accv_in;
      ast_ff <= ast_in;
      asz_ff <= asz_in;
      p_ff <= p_in;
      k_ff <= k_in;
      max_ff <= max_in;
      status_ff <= status_in;
      addr_ff <= addr_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== src/bfia_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_interval_allocator_defines.svh"
module bfia_checker
   import bfia_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire rsp_type rsp_payload,
   input wire logic    rsp_strobe
);

   logic rsp_bad;

   assign rsp_bad = rsp_strobe && (rsp_payload.status != STS_OK);

   `BFIA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `BFIA_ASSERT_NXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe)
   `BFIA_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `BFIA_ASSERT_IMP(a_addr_zero, clock, reset, rsp_bad, rsp_payload.alloc_addr == '0)

endmodule

bind best_fit_interval_allocator bfia_checker u_bfia_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_payload(rsp_payload),
   .rsp_strobe(rsp_strobe)
);
`default_nettype wire

// ===== tb/tb_best_fit_interval_allocator.sv =====
// Self-checking testbench for the best-fit interval allocator.
`timescale 1ns / 1ps
`default_nettype none
module tb_best_fit_interval_allocator;
   import bfia_pkg::*;

   localparam int N_SLOTS = 64;
   localparam int ABITS = 20;
   localparam logic [SIZE_W-1:0] SZ_MAX = '1;
   localparam logic [SIZE_W-1:0] HEAP_LIM = SIZE_W'(1 << ABITS);
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [ABITS+1:0] start;
      logic [SIZE_W-1:0] size;
   } span_t;

   typedef struct {
      req_type req;
      logic chk;
      rsp_type rsp;
   } row_t;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_wr_en = 0;
   logic [SIZE_W-1:0] csr_wr_data = '0;

   best_fit_interval_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   span_t free_list[N_SLOTS];
   int span_count;
   logic [SIZE_W-1:0] live_total;
   rsp_type pending_rsp[$];
   logic pending_chk[$];
   rsp_type pending_fix[$];
   int errors = 0;
   int idle_cycles = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void heap_init(input logic [SIZE_W-1:0] hs);
      logic [SIZE_W-1:0] h;
      h = (hs > HEAP_LIM) ? HEAP_LIM : hs;
      span_count = 0;
      if (h != 0) begin
         free_list[0].start = 0;
         free_list[0].size = h;
         span_count = 1;
      end
      live_total = 0;
   endfunction

   function automatic logic [SIZE_W-1:0] largest_span();
      logic [SIZE_W-1:0] m;
      m = 0;
      for (int i = 0; i < span_count; i++) if (free_list[i].size > m) m = free_list[i].size;
      return m;
   endfunction

   function automatic void coalesce_spans();
      span_t cur;
      int j, k;
      if (span_count == 0) return;
      for (int i = 1; i < span_count; i++) begin
         cur = free_list[i];
         j = i;
         while (j > 0 && (free_list[j-1].start > cur.start ||
               (free_list[j-1].start == cur.start && free_list[j-1].size > cur.size))) begin
            free_list[j] = free_list[j-1];
            j--;
         end
         free_list[j] = cur;
      end
      k = 0;
      for (int i = 1; i < span_count; i++) begin
         if ({1'b0, free_list[k].start} + free_list[k].size == {1'b0, free_list[i].start} &&
             {1'b0, free_list[k].size} + free_list[i].size <= SZ_MAX)
            free_list[k].size = free_list[k].size + free_list[i].size;
         else begin
            k++;
            free_list[k] = free_list[i];
         end
      end
      span_count = k + 1;
   endfunction

   function automatic rsp_type predict_alloc_step(input req_type r);
      rsp_type o;
      logic found;
      int best;
      logic [SIZE_W:0] sum;
      o = '0;
      o.status = STS_OK;
      if (r.cmd == CMD_ALLOC) begin
         found = 0;
         best = 0;
         for (int i = 0; i < span_count; i++) begin
            if (free_list[i].size < r.req_size) continue;
            if (!found || free_list[i].size < free_list[best].size ||
                (free_list[i].size == free_list[best].size &&
                 free_list[i].start < free_list[best].start)) begin
               found = 1;
               best = i;
            end
         end
         if (!found) o.status = STS_FAIL;
         else begin
            o.alloc_addr = free_list[best].start[ABITS-1:0];
            if (free_list[best].size == r.req_size) begin
               span_count--;
               free_list[best] = free_list[span_count];
            end else begin
               free_list[best].start = free_list[best].start + r.req_size;
               free_list[best].size = free_list[best].size - r.req_size;
            end
            sum = {1'b0, live_total} + r.req_size;
            live_total = (sum > SZ_MAX) ? SZ_MAX : sum[SIZE_W-1:0];
         end
      end else if (r.cmd == CMD_FREE) begin
         if (r.req_size != 0) begin
            if (span_count >= N_SLOTS) o.status = STS_FULL;
            else begin
               free_list[span_count].start = {2'b0, r.free_start};
               free_list[span_count].size = r.req_size;
               span_count++;
               live_total = (live_total > r.req_size) ? live_total - r.req_size : 0;
            end
         end
      end else if (r.cmd == CMD_MERGE) coalesce_spans();
      o.largest_free = largest_span();
      o.used_bytes = live_total;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type w, f;
      logic c;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
      if (rsp_strobe) begin
         if (pending_rsp.size() == 0) report("unexpected transaction", rsp_payload, 0);
         else begin
            w = pending_rsp.pop_front();
            c = pending_chk.pop_front();
            f = pending_fix.pop_front();
            if (rsp_payload.status !== w.status)
               report("status", 64'(rsp_payload.status), 64'(w.status));
            if (rsp_payload.alloc_addr !== w.alloc_addr)
               report("alloc_addr", 64'(rsp_payload.alloc_addr), 64'(w.alloc_addr));
            if (rsp_payload.largest_free !== w.largest_free)
               report("largest_free", 64'(rsp_payload.largest_free), 64'(w.largest_free));
            if (rsp_payload.used_bytes !== w.used_bytes)
               report("used_bytes", 64'(rsp_payload.used_bytes), 64'(w.used_bytes));
            if (c && rsp_payload !== f) report("table row", rsp_payload, f);
         end
      end
   end

   task automatic random_gap();
      int g;
      g = $urandom_range(0, 99);
      if (g < 40) g = 0;
      else if (g < 90) g = $urandom_range(1, 3);
      else g = $urandom_range(5, 40);
      repeat (g) @(negedge clock);
   endtask

   task automatic enqueue(input req_type r, input logic chk, input rsp_type fixed);
      pending_rsp.insert(pending_rsp.size(), predict_alloc_step(r));
      pending_chk.insert(pending_chk.size(), chk);
      pending_fix.insert(pending_fix.size(), fixed);
   endtask

   task automatic issue(input req_type r, input logic chk, input rsp_type fixed);
      @(negedge clock);
      req_payload <= r;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      enqueue(r, chk, fixed);
      @(negedge clock);
      start <= 0;
      @(negedge clock);
   endtask

   task automatic issue_stream(input req_type r);
      req_payload <= r;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      enqueue(r, 1'b0, '0);
      @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic set_heap(input logic [SIZE_W-1:0] hs);
      drain();
      csr_wr_data <= hs;
      csr_wr_en <= 1;
      @(negedge clock);
      csr_wr_en <= 0;
      heap_init(hs);
   endtask

   function automatic req_type mk(input logic [1:0] c, input logic [SIZE_W-1:0] s,
                                  input logic [ABITS-1:0] a);
      req_type r;
      r.cmd = c;
      r.req_size = s;
      r.free_start = a;
      return r;
   endfunction

   function automatic rsp_type rs(input logic [1:0] st, input logic [ABITS-1:0] a,
                                  input logic [SIZE_W-1:0] m, input logic [SIZE_W-1:0] u);
      rsp_type o;
      o.status = st;
      o.alloc_addr = a;
      o.largest_free = m;
      o.used_bytes = u;
      return o;
   endfunction

   task automatic random_phase(input int n, input int span);
      req_type r;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 40) r = mk(CMD_ALLOC, SIZE_W'($urandom_range(0, span)), '0);
         else if (k < 75)
            r = mk(CMD_FREE, SIZE_W'($urandom_range(0, span)),
                   ABITS'($urandom_range(0, 4 * span)));
         else if (k < 85) r = mk(CMD_MERGE, SIZE_W'($urandom), ABITS'($urandom));
         else if (k < 88) r = mk(2'd3, SIZE_W'($urandom), ABITS'($urandom));
         else if (k < 94) r = mk(CMD_ALLOC, SIZE_W'($urandom), '0);
         else r = mk(CMD_FREE, SIZE_W'($urandom), ABITS'($urandom));
         if ($urandom_range(0, 3) == 0) issue_stream(r);
         else begin
            issue(r, 1'b0, '0);
            random_gap();
         end
      end
      @(negedge clock);
      start <= 0;
   endtask

   row_t directed[$];

   task automatic add_row(input req_type r, input logic chk, input rsp_type e);
      row_t row;
      row.req = r;
      row.chk = chk;
      row.rsp = e;
      directed.insert(directed.size(), row);
   endtask

   initial begin
      heap_init(21'd65536);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      add_row(mk(CMD_ALLOC, 0, 0), 1'b1, rs(STS_OK, 0, 65536, 0));
      add_row(mk(CMD_ALLOC, 100, 0), 1'b1, rs(STS_OK, 0, 65436, 100));
      add_row(mk(CMD_ALLOC, SZ_MAX, 0), 1'b1, rs(STS_FAIL, 0, 65436, 100));
      add_row(mk(CMD_FREE, 0, 5), 1'b1, rs(STS_OK, 0, 65436, 100));
      add_row(mk(CMD_FREE, 100, 0), 1'b0, '0);
      add_row(mk(CMD_MERGE, 0, 0), 1'b1, rs(STS_OK, 0, 65536, 0));
      add_row(mk(2'd3, SZ_MAX, '1), 1'b1, rs(STS_OK, 0, 65536, 0));
      add_row(mk(CMD_ALLOC, 65536, 0), 1'b1, rs(STS_OK, 0, 0, 65536));
      add_row(mk(CMD_ALLOC, 0, 0), 1'b1, rs(STS_FAIL, 0, 0, 65536));
      add_row(mk(CMD_FREE, SZ_MAX, '1), 1'b0, '0);
      add_row(mk(CMD_FREE, SZ_MAX, 0), 1'b0, '0);
      add_row(mk(CMD_MERGE, 0, 0), 1'b0, '0);
      add_row(mk(CMD_ALLOC, SZ_MAX, 0), 1'b0, '0);
      add_row(mk(CMD_FREE, 7, 20'h55555), 1'b0, '0);
      add_row(mk(CMD_FREE, 7, 20'h2aaaa), 1'b0, '0);
      add_row(mk(CMD_ALLOC, 7, 0), 1'b0, '0);
      foreach (directed[i]) issue(directed[i].req, directed[i].chk, directed[i].rsp);
      // fill the table to hit the full status
      for (int i = 0; i < 66; i++) issue_stream(mk(CMD_FREE, 1, ABITS'(2 * i + 9)));
      issue(mk(CMD_MERGE, 0, 0), 1'b0, '0);

      set_heap(21'd0);
      issue(mk(CMD_ALLOC, 0, 0), 1'b1, rs(STS_FAIL, 0, 0, 0));
      set_heap(SZ_MAX);
      issue(mk(CMD_ALLOC, 0, 0), 1'b1, rs(STS_OK, 0, 21'h100000, 0));
      random_phase(120, 1 << 18);
      set_heap(21'd1);
      random_phase(60, 2);
      drain();
      set_heap(21'd4096);
      random_phase(200, 300);
      set_heap(21'd65536);
      random_phase(200, 5000);
      drain();
      repeat (300) @(negedge clock);
      if (errors == 0 && pending_rsp.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/bfia_pkg.sv
src/best_fit_interval_allocator.sv
src/bfia_checker.sv
tb/tb_best_fit_interval_allocator.sv
